// ===== hdl/tcpq_pkg.sv =====
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

	localparam int unsigned ID_W   = 16;
	localparam int unsigned AGE_W  = 7;
	localparam int unsigned PRIO_W = 4;
	localparam int unsigned STAT_W = 3;

	// Request command codes.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_SERVE = 1'b1;

	// Response status codes.
	localparam logic [STAT_W-1:0] ST_ADDED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_URGENT = 3'd1;
	localparam logic [STAT_W-1:0] ST_NORMAL = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

	// Threshold value after reset.
	localparam logic [PRIO_W-1:0] THRESHOLD_RESET = 4'd5;

	// One queued entry.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [AGE_W-1:0]  age;
		logic [PRIO_W-1:0] prio;
	} ent_t;

	// Command broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic insert;
		logic pop;
		ent_t ent;
	} cell_cmd_t;

endpackage

// ===== hdl/tcpq_ifs.sv =====
// Request, response and configuration channel interfaces.
interface tcpq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [tcpq_pkg::ID_W-1:0]     entry_id;
	logic [tcpq_pkg::AGE_W-1:0]    entry_age;
	logic [tcpq_pkg::PRIO_W-1:0]   entry_priority;

	modport source(output valid, command, entry_id, entry_age, entry_priority, input ready);
	modport sink(input valid, command, entry_id, entry_age, entry_priority, output ready);
endinterface

interface tcpq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcpq_pkg::STAT_W-1:0]   status;
	logic [tcpq_pkg::ID_W-1:0]     served_id;
	logic [tcpq_pkg::AGE_W-1:0]    served_age;
	logic [tcpq_pkg::PRIO_W-1:0]   served_priority;

	modport source(output valid, status, served_id, served_age, served_priority, input ready);
	modport sink(input valid, status, served_id, served_age, served_priority, output ready);
endinterface

interface tcpq_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tcpq_pkg::PRIO_W-1:0]   data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== hdl/tcpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcpq_ram #(
	parameter int unsigned WIDTH = 27,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/tcpq_cell.sv =====
// One cell of the sorted urgent chain: holds one entry and trades with its neighbors.
module tcpq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcpq_pkg::cell_cmd_t   cmd,
	input  tcpq_pkg::ent_t        left_ent,
	input  logic                  left_vld,
	input  tcpq_pkg::ent_t        right_ent,
	input  logic                  right_vld,
	output tcpq_pkg::ent_t        ent_q,
	output logic                  vld_q
);

	logic left_shifts;
	logic new_here;

	// The left neighbor is displaced when it holds a lower priority than the new entry.
	// The new entry lands in the first cell whose own entry is lower or empty.
	assign left_shifts = left_vld && (left_ent.prio < cmd.ent.prio);
	assign new_here    = left_vld && !left_shifts && (!vld_q || (ent_q.prio < cmd.ent.prio));

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.pop) begin
			vld_q <= right_vld;
		end else if (cmd.insert && (left_shifts || new_here)) begin
			vld_q <= 1'b1;
		end
	end

	// Entry payload of the cell.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			ent_q <= right_ent;
		end else if (cmd.insert && left_shifts) begin
			ent_q <= left_ent;
		end else if (cmd.insert && new_here) begin
			ent_q <= cmd.ent;
		end
	end

endmodule

// ===== hdl/tcpq_urgent.sv =====
// Sorted urgent queue built as a row of cells, head in the first cell.
module tcpq_urgent #(
	parameter int unsigned URGENT_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcpq_pkg::cell_cmd_t   cmd,
	output tcpq_pkg::ent_t        head_ent,
	output logic                  head_vld,
	output logic                  full
);

	tcpq_pkg::ent_t ent   [URGENT_DEPTH];
	logic           vld   [URGENT_DEPTH];
	tcpq_pkg::ent_t lft_e [URGENT_DEPTH];
	logic           lft_v [URGENT_DEPTH];
	tcpq_pkg::ent_t rgt_e [URGENT_DEPTH];
	logic           rgt_v [URGENT_DEPTH];

	// Neighbor wiring; the chain start looks like a valid top-priority entry,
	// and the chain end looks empty.
	for (genvar i = 0; i < URGENT_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lft_e[i] = '{id: '0, age: '0, prio: '1};
			assign lft_v[i] = 1'b1;
		end else begin : g_mid_l
			assign lft_e[i] = ent[i-1];
			assign lft_v[i] = vld[i-1];
		end
		if (i == URGENT_DEPTH - 1) begin : g_last
			assign rgt_e[i] = '0;
			assign rgt_v[i] = 1'b0;
		end else begin : g_mid_r
			assign rgt_e[i] = ent[i+1];
			assign rgt_v[i] = vld[i+1];
		end

		tcpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_ent  (lft_e[i]),
			.left_vld  (lft_v[i]),
			.right_ent (rgt_e[i]),
			.right_vld (rgt_v[i]),
			.ent_q     (ent[i]),
			.vld_q     (vld[i])
		);
	end

	// Occupied cells are always packed toward the head.
	assign head_ent = ent[0];
	assign head_vld = vld[0];
	assign full     = vld[URGENT_DEPTH-1];

endmodule

// ===== hdl/two_class_priority_queue.sv =====
// Top level: urgent sorted chain, normal FIFO in RAM, response staging.
// An accepted request passes through stage 1 and then the response register;
// stage 1 holds while a pending response is not taken.
// Throughput: one request per cycle while responses are taken; stage 1
// waits for the registered read port of the normal-queue RAM.
// Reset clears the chain valid bits, FIFO pointers and count, the pipeline,
// and sets the threshold to 5; the FIFO RAM is not cleared.
module two_class_priority_queue #(
	parameter int unsigned URGENT_DEPTH = 16,
	parameter int unsigned NORMAL_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	tcpq_req_if.sink   req,
	tcpq_rsp_if.source rsp,
	tcpq_cfg_if.sink   cfg
);

	localparam int unsigned NPTR_W = $clog2(NORMAL_DEPTH);
	localparam int unsigned NCNT_W = $clog2(NORMAL_DEPTH + 1);
	localparam int unsigned ENT_W  = $bits(tcpq_pkg::ent_t);

	logic [tcpq_pkg::PRIO_W-1:0] thr_q;
	logic [NPTR_W-1:0]           nrm_head_q;
	logic [NPTR_W-1:0]           nrm_tail_q;
	logic [NCNT_W-1:0]           nrm_count_q;

	tcpq_pkg::cell_cmd_t         ucmd;
	tcpq_pkg::ent_t              uhead;
	logic                        uhead_vld;
	logic                        ufull;

	tcpq_pkg::ent_t              new_ent;
	logic                        accept;
	logic                        is_add;
	logic                        is_urg;
	logic                        nrm_full;
	logic                        nrm_empty;
	logic                        add_urg;
	logic                        add_nrm;
	logic                        srv_urg;
	logic                        srv_nrm;
	logic [tcpq_pkg::STAT_W-1:0] status_d;

	logic                        valid_s1;
	logic                        from_ram_s1;
	logic [tcpq_pkg::STAT_W-1:0] status_s1;
	tcpq_pkg::ent_t              ent_s1;
	logic                        advance_s1;

	logic [ENT_W-1:0]            ram_rdata;
	tcpq_pkg::ent_t              ram_ent;

	logic                        rsp_valid_q;
	logic [tcpq_pkg::STAT_W-1:0] status_q;
	tcpq_pkg::ent_t              served_q;

	// Configuration register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tcpq_pkg::THRESHOLD_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	// Request decode.
	assign advance_s1 = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready  = !valid_s1 || advance_s1;
	assign accept     = req.valid && req.ready;

	assign new_ent   = '{id: req.entry_id, age: req.entry_age, prio: req.entry_priority};
	assign is_add    = (req.command == tcpq_pkg::CMD_ADD);
	assign is_urg    = (req.entry_priority > thr_q);
	assign nrm_full  = (nrm_count_q == NCNT_W'(NORMAL_DEPTH));
	assign nrm_empty = (nrm_count_q == '0);

	assign add_urg = accept && is_add && is_urg && !ufull;
	assign add_nrm = accept && is_add && !is_urg && !nrm_full;
	assign srv_urg = accept && !is_add && uhead_vld;
	assign srv_nrm = accept && !is_add && !uhead_vld && !nrm_empty;

	// Status of the request.
	always_comb begin
		if (is_add) begin
			status_d = (is_urg ? ufull : nrm_full) ? tcpq_pkg::ST_FULL : tcpq_pkg::ST_ADDED;
		end else if (uhead_vld) begin
			status_d = tcpq_pkg::ST_URGENT;
		end else if (!nrm_empty) begin
			status_d = tcpq_pkg::ST_NORMAL;
		end else begin
			status_d = tcpq_pkg::ST_EMPTY;
		end
	end

	// Sorted urgent chain.
	assign ucmd = '{insert: add_urg, pop: srv_urg, ent: new_ent};

	tcpq_urgent #(
		.URGENT_DEPTH (URGENT_DEPTH)
	) u_urgent (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ucmd),
		.head_ent (uhead),
		.head_vld (uhead_vld),
		.full     (ufull)
	);

	// Normal FIFO storage.
	tcpq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NORMAL_DEPTH)
	) u_nrm_ram (
		.clk   (clk),
		.we    (add_nrm),
		.waddr (nrm_tail_q),
		.wdata (new_ent),
		.re    (srv_nrm),
		.raddr (nrm_head_q),
		.rdata (ram_rdata)
	);

	assign ram_ent = ram_rdata;

	// Normal FIFO pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_head_q  <= '0;
			nrm_tail_q  <= '0;
			nrm_count_q <= '0;
		end else begin
			if (add_nrm) begin
				nrm_tail_q <= (nrm_tail_q == NPTR_W'(NORMAL_DEPTH - 1)) ? '0 : nrm_tail_q + 1'b1;
			end
			if (srv_nrm) begin
				nrm_head_q <= (nrm_head_q == NPTR_W'(NORMAL_DEPTH - 1)) ? '0 : nrm_head_q + 1'b1;
			end
			if (add_nrm) begin
				nrm_count_q <= nrm_count_q + 1'b1;
			end else if (srv_nrm) begin
				nrm_count_q <= nrm_count_q - 1'b1;
			end
		end
	end

	// Stage 1: status and urgent head wait while the RAM read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= status_d;
			from_ram_s1 <= srv_nrm;
			ent_s1      <= srv_urg ? uhead : '0;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_q <= status_s1;
			served_q <= from_ram_s1 ? ram_ent : ent_s1;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.served_id       = served_q.id;
	assign rsp.served_age      = served_q.age;
	assign rsp.served_priority = served_q.prio;

	// A full chain always has a head.
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		ufull |-> uhead_vld)
		else $error("urgent chain full without a head entry");

	// The normal count never passes the FIFO depth.
	a_nrm_count: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_count_q <= NCNT_W'(NORMAL_DEPTH))
		else $error("normal queue count exceeds depth");

	// A serve with an urgent head pending reports an urgent serve.
	a_urgent_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_add && uhead_vld) |=> (status_s1 == tcpq_pkg::ST_URGENT))
		else $error("serve skipped a pending urgent entry");

	// A stalled stage 1 keeps its request.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(status_s1)))
		else $error("stage 1 request lost while stalled");

endmodule
